/* rtl/cma_pkg.sv */
package cma_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int WLEN_W      = 5;
    localparam int HALF_W      = 4;
    localparam int POS_W       = 5;
    localparam int POS_MAX     = 2 ** POS_W - 1;
    localparam int SUM_W       = 21;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0]
    {
        CMD_PASS,
        CMD_STORE,
        CMD_EMIT
    } cmd_kind_t;

    // pos: stream position of the newest sample, clamped to POS_MAX
    typedef struct packed
    {
        cmd_kind_t                  kind;
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
        logic [POS_W-1:0]           pos;
        logic [HALF_W-1:0]          half;
    } cmd_t;

    typedef enum logic [1:0]
    {
        B_IDLE,
        B_SUM,
        B_DIV,
        B_PUT
    } back_state_t;

endpackage

/* rtl/centered_moving_average_unit.sv */
// Centered moving average over a stream of signed 16-bit samples.
// Input beats arrive on s_axis (tdata = sample, tlast = end of stream);
// result beats leave on m_axis (tdata = average, tlast = final result).
// The window register is written through cfg_valid/cfg_data; the user must
// write it only while the block is idle, as the block itself does not
// enforce this. 0 or 1 passes samples through, other values give an odd
// window W of at least 3, and each result is the mean of the present
// samples of the centered window, truncated toward zero. The result for
// position p leaves after sample p+W/2 arrives; the sample with tlast
// flushes every pending result of the stream, in order. Each averaged
// result reads its window, the top+1 samples averaged (at most W), from
// the history RAM one entry per cycle and then runs a 21-step restoring
// divider.
// A two-entry command queue separates the input classifier from the
// averaging engine; it takes input beats while the engine works, until full.
// The result sits in an output register; a stalled receiver holds it there
// and the engine waits only when it has the next result ready.
// Reset clears the window register (pass-through), the stream position and
// all valid flags; the history RAM needs no clearing.
module centered_moving_average_unit #(
    parameter int MAX_WINDOW = 31
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [4:0]  cfg_data,       // window_length
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] sample
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] average
    output logic        m_axis_tlast
);

    import cma_pkg::*;

    localparam int HIST_DEPTH = (MAX_WINDOW < POS_MAX) ? MAX_WINDOW : POS_MAX;
    localparam int ADDR_W     = $clog2(HIST_DEPTH);

    cmd_t push_cmd;
    cmd_t pop_cmd;
    logic push;
    logic pop;
    logic full;
    logic empty;

    cma_front #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .push          (push),
        .push_cmd      (push_cmd),
        .full          (full)
    );

    cma_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (full),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .empty    (empty)
    );

    cma_back #(
        .ADDR_W (ADDR_W)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .pop           (pop),
        .pop_cmd       (pop_cmd),
        .empty         (empty),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

/* rtl/cma_ram.sv */
module cma_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/cma_queue.sv */
module cma_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  cma_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output cma_pkg::cmd_t pop_cmd,
    output logic          empty
);

    import cma_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);

    cmd_t          slot_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] rd_ptr_next;
    logic [PW:0]   count_reg;
    logic [PW:0]   count_next;

    assign full    = (count_reg == (PW+1)'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign pop_cmd = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + PW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + PW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + (PW+1)'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - (PW+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

/* rtl/cma_front.sv */
module cma_front #(
    parameter int MAX_WINDOW = 31
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [cma_pkg::WLEN_W-1:0]    cfg_data,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [cma_pkg::SAMPLE_W-1:0]  s_axis_tdata,
    input  logic                          s_axis_tlast,
    output logic                          push,
    output cma_pkg::cmd_t                 push_cmd,
    input  logic                          full
);

    import cma_pkg::*;

    localparam int CNT_W   = $clog2(MAX_WINDOW + 1);
    localparam int WIN_TOP = (MAX_WINDOW % 2 == 1) ? MAX_WINDOW : MAX_WINDOW - 1;

    logic [WLEN_W-1:0] wlen_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [CNT_W-1:0]  count_inc;
    logic [CNT_W-1:0]  pos_full;
    logic [POS_W-1:0]  pos;
    logic [WLEN_W-1:0] win_odd;
    logic [WLEN_W-1:0] win_eff;
    logic [HALF_W-1:0] half;
    logic              pass;
    logic              accept;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = !full;
    assign accept        = s_axis_tvalid && !full;
    assign push          = accept;

    always_comb
    begin
        pass    = (wlen_reg <= WLEN_W'(1));
        // raise an even window to odd, then limit it to the largest odd window
        win_odd = wlen_reg | WLEN_W'(1);
        if (int'(win_odd) > WIN_TOP)
        begin
            win_eff = WLEN_W'(WIN_TOP);
        end
        else
        begin
            win_eff = win_odd;
        end
        half = win_eff[WLEN_W-1:1];

        count_inc = (count_reg < CNT_W'(MAX_WINDOW)) ? count_reg + CNT_W'(1) : count_reg;
        pos_full  = count_inc - CNT_W'(1);
        if (int'(pos_full) > POS_MAX)
        begin
            pos = POS_W'(POS_MAX);
        end
        else
        begin
            pos = POS_W'(pos_full);
        end

        push_cmd.sample = s_axis_tdata;
        push_cmd.last   = s_axis_tlast;
        push_cmd.pos    = pos;
        push_cmd.half   = half;
        if (pass)
        begin
            push_cmd.kind = CMD_PASS;
        end
        else if (s_axis_tlast || (pos >= POS_W'(half)))
        begin
            push_cmd.kind = CMD_EMIT;
        end
        else
        begin
            push_cmd.kind = CMD_STORE;
        end

        count_next = count_reg;
        if (accept)
        begin
            if (s_axis_tlast)
            begin
                count_next = '0;
            end
            else if (!pass)
            begin
                count_next = count_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wlen_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                wlen_reg <= cfg_data;
            end
            count_reg <= count_next;
        end
    end

endmodule

/* rtl/cma_back.sv */
module cma_back #(
    parameter int ADDR_W = 5
) (
    input  logic                          clk,
    input  logic                          rst_n,
    output logic                          pop,
    input  cma_pkg::cmd_t                 pop_cmd,
    input  logic                          empty,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [cma_pkg::SAMPLE_W-1:0]  m_axis_tdata,
    output logic                          m_axis_tlast
);

    import cma_pkg::*;

    localparam int STEP_W = $clog2(SUM_W);

    back_state_t         state_reg;
    back_state_t         state_next;

    logic [SAMPLE_W-1:0] sample_reg;
    logic [SAMPLE_W-1:0] sample_next;
    logic                pass_reg;
    logic                pass_next;
    logic                last_reg;
    logic                last_next;
    logic [POS_W-1:0]    pos_reg;
    logic [POS_W-1:0]    pos_next;
    logic [HALF_W-1:0]   half_reg;
    logic [HALF_W-1:0]   half_next;
    logic [HALF_W-1:0]   dist_reg;
    logic [HALF_W-1:0]   dist_next;
    logic [ADDR_W-1:0]   newest_reg;
    logic [ADDR_W-1:0]   newest_next;
    logic [POS_W-1:0]    tap_reg;
    logic [POS_W-1:0]    tap_next;
    logic                issuing_reg;
    logic                issuing_next;
    logic                rvalid_reg;
    logic                rvalid_next;
    logic                rlast_reg;
    logic                rlast_next;
    logic [SUM_W-1:0]    acc_reg;
    logic [SUM_W-1:0]    acc_next;
    logic [SUM_W-1:0]    quo_reg;
    logic [SUM_W-1:0]    quo_next;
    logic [POS_W-1:0]    rem_reg;
    logic [POS_W-1:0]    rem_next;
    logic [STEP_W-1:0]   step_reg;
    logic [STEP_W-1:0]   step_next;
    logic                neg_reg;
    logic                neg_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [SAMPLE_W-1:0] out_data_reg;
    logic [SAMPLE_W-1:0] out_data_next;
    logic                out_last_reg;
    logic                out_last_next;

    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    logic                rd_en;
    logic [ADDR_W-1:0]   rd_addr;
    logic [SAMPLE_W-1:0] rd_data;

    logic [POS_W-1:0]    reach;
    logic [POS_W-1:0]    top;
    logic [POS_W-1:0]    divisor;
    logic [SUM_W-1:0]    acc_sum;
    logic [POS_W:0]      rem_shift;
    logic                rem_ge;
    logic [SUM_W-1:0]    div_val;
    logic [SAMPLE_W-1:0] res_val;
    logic                res_last;
    logic                out_free;
    logic                more;

    cma_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (2 ** ADDR_W)
    ) u_hist_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (pop_cmd.sample),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

    // window covers the newest top+1 samples
    assign reach     = POS_W'(dist_reg) + POS_W'(half_reg);
    assign top       = (pos_reg < reach) ? pos_reg : reach;
    assign divisor   = top + POS_W'(1);
    assign acc_sum   = acc_reg + {{(SUM_W-SAMPLE_W){rd_data[SAMPLE_W-1]}}, rd_data};
    assign rem_shift = {rem_reg, quo_reg[SUM_W-1]};
    assign rem_ge    = (rem_shift >= {1'b0, divisor});
    assign div_val   = neg_reg ? (SUM_W'(0) - quo_reg) : quo_reg;
    assign res_val   = pass_reg ? sample_reg : div_val[SAMPLE_W-1:0];
    assign res_last  = pass_reg ? last_reg : (last_reg && (dist_reg == '0));
    assign out_free  = !out_valid_reg || m_axis_tready;
    assign more      = !pass_reg && last_reg && (dist_reg != '0);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (!empty)
                begin
                    unique case (pop_cmd.kind)
                        CMD_PASS:  state_next = B_PUT;
                        CMD_EMIT:  state_next = B_SUM;
                        default:   state_next = B_IDLE;
                    endcase
                end
            end
            B_SUM:
            begin
                if (rvalid_reg && rlast_reg)
                begin
                    state_next = B_DIV;
                end
            end
            B_DIV:
            begin
                if (step_reg == STEP_W'(SUM_W - 1))
                begin
                    state_next = B_PUT;
                end
            end
            B_PUT:
            begin
                if (out_free)
                begin
                    state_next = more ? B_SUM : B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_comb
    begin
        sample_next    = sample_reg;
        pass_next      = pass_reg;
        last_next      = last_reg;
        pos_next       = pos_reg;
        half_next      = half_reg;
        dist_next      = dist_reg;
        newest_next    = newest_reg;
        tap_next       = tap_reg;
        issuing_next   = issuing_reg;
        rvalid_next    = 1'b0;
        rlast_next     = 1'b0;
        acc_next       = acc_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        step_next      = step_reg;
        neg_next       = neg_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        pop            = 1'b0;
        wr_en          = 1'b0;
        wr_addr        = newest_reg + ADDR_W'(1);
        rd_en          = 1'b0;
        rd_addr        = newest_reg - ADDR_W'(tap_reg);

        unique case (state_reg)
            B_IDLE:
            begin
                if (!empty)
                begin
                    pop         = 1'b1;
                    sample_next = pop_cmd.sample;
                    last_next   = pop_cmd.last;
                    pos_next    = pop_cmd.pos;
                    half_next   = pop_cmd.half;
                    pass_next   = (pop_cmd.kind == CMD_PASS);
                    if (pop_cmd.kind != CMD_PASS)
                    begin
                        wr_en       = 1'b1;
                        newest_next = newest_reg + ADDR_W'(1);
                    end
                    // flush starts half a window back, or at the stream head
                    if (pop_cmd.last && (pop_cmd.pos < POS_W'(pop_cmd.half)))
                    begin
                        dist_next = pop_cmd.pos[HALF_W-1:0];
                    end
                    else
                    begin
                        dist_next = pop_cmd.half;
                    end
                    tap_next     = '0;
                    issuing_next = 1'b1;
                    acc_next     = '0;
                end
            end
            B_SUM:
            begin
                if (issuing_reg)
                begin
                    rd_en       = 1'b1;
                    rvalid_next = 1'b1;
                    rlast_next  = (tap_reg == top);
                    tap_next    = tap_reg + POS_W'(1);
                    if (tap_reg == top)
                    begin
                        issuing_next = 1'b0;
                    end
                end
                if (rvalid_reg)
                begin
                    acc_next = acc_sum;
                    if (rlast_reg)
                    begin
                        neg_next  = acc_sum[SUM_W-1];
                        quo_next  = acc_sum[SUM_W-1] ? (SUM_W'(0) - acc_sum) : acc_sum;
                        rem_next  = '0;
                        step_next = '0;
                    end
                end
            end
            B_DIV:
            begin
                rem_next  = rem_ge ? POS_W'(rem_shift - {1'b0, divisor}) : rem_shift[POS_W-1:0];
                quo_next  = {quo_reg[SUM_W-2:0], rem_ge};
                step_next = step_reg + STEP_W'(1);
            end
            B_PUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_val;
                    out_last_next  = res_last;
                    if (more)
                    begin
                        dist_next    = dist_reg - HALF_W'(1);
                        tap_next     = '0;
                        issuing_next = 1'b1;
                        acc_next     = '0;
                    end
                end
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            newest_reg    <= '0;
            issuing_reg   <= 1'b0;
            rvalid_reg    <= 1'b0;
            rlast_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            newest_reg    <= newest_next;
            issuing_reg   <= issuing_next;
            rvalid_reg    <= rvalid_next;
            rlast_reg     <= rlast_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg   <= sample_next;
        pass_reg     <= pass_next;
        last_reg     <= last_next;
        pos_reg      <= pos_next;
        half_reg     <= half_next;
        dist_reg     <= dist_next;
        tap_reg      <= tap_next;
        acc_reg      <= acc_next;
        quo_reg      <= quo_next;
        rem_reg      <= rem_next;
        step_reg     <= step_next;
        neg_reg      <= neg_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

endmodule

/* rtl/cma_checker.sv */
module cma_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    // a stalled result beat stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result beat dropped while stalled");

    // and keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("result payload changed while stalled");

    // nothing is offered straight out of reset
    assert property (@(posedge clk)
        $rose(rst_n) |-> !m_axis_tvalid)
        else $error("result beat offered out of reset");

    // the queue fills only through an accepted input beat
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(s_axis_tready) |-> $past(s_axis_tvalid && s_axis_tready))
        else $error("input ready dropped without an accepted beat");

endmodule

bind centered_moving_average_unit cma_checker u_cma_checker (.*);

/* sim/cma_result_checker.sv */
module cma_result_checker
    import cma_pkg::*;
#(
    parameter int MAX_WINDOW = 31
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  logic [WLEN_W-1:0]   cfg_data,
    input  logic                s_axis_tvalid,
    input  logic                s_axis_tready,
    input  logic [SAMPLE_W-1:0] s_axis_tdata,
    input  logic                s_axis_tlast,
    input  logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    input  logic [SAMPLE_W-1:0] m_axis_tdata,
    input  logic                m_axis_tlast,
    output int                  fail_count,
    output int                  pending
);

    typedef struct packed
    {
        logic signed [SAMPLE_W-1:0] average;
        logic                       last_res;
    } mean_beat_t;

    logic [WLEN_W-1:0]          window_reg;
    logic signed [SAMPLE_W-1:0] recent [MAX_WINDOW];
    int                         stream_count;
    int                         mismatches;
    mean_beat_t                 mean_queue [$];

    // Mean of recent[0..top], truncated toward zero.
    function automatic logic signed [SAMPLE_W-1:0] clipped_mean(input int top);
        int total;
        int n;
        total = 0;
        if (top > MAX_WINDOW - 1)
            top = MAX_WINDOW - 1;
        for (n = 0; n <= top; n++)
            total += recent[n];
        return SAMPLE_W'(total / (top + 1));
    endfunction

    function automatic void push_mean(input logic signed [SAMPLE_W-1:0] value, input logic fin);
        mean_beat_t beat;
        beat.average  = value;
        beat.last_res = fin;
        mean_queue.push_back(beat);
    endfunction

    function automatic void predict_means(input logic signed [SAMPLE_W-1:0] smp, input logic fin);
        int w;
        int half;
        int pos;
        int lead;
        int k;
        if (window_reg <= 1) begin
            push_mean(smp, fin);
            if (fin)
                stream_count = 0;
            return;
        end
        w = window_reg;
        if (w % 2 == 0)
            w++;
        if (w < 3)
            w = 3;
        if (w > MAX_WINDOW)
            w = (MAX_WINDOW % 2 == 1) ? MAX_WINDOW : MAX_WINDOW - 1;
        half = w / 2;

        for (k = MAX_WINDOW - 1; k > 0; k--)
            recent[k] = recent[k-1];
        recent[0] = smp;
        if (stream_count < MAX_WINDOW)
            stream_count++;
        pos = stream_count - 1;

        if (!fin) begin
            if (pos >= half)
                push_mean(clipped_mean((pos < 2 * half) ? pos : 2 * half), 1'b0);
        end
        else begin
            // flush every pending position, oldest first
            lead = (pos < half) ? pos : half;
            forever begin
                push_mean(clipped_mean((pos < lead + half) ? pos : lead + half), lead == 0);
                if (lead == 0)
                    break;
                lead--;
            end
            stream_count = 0;
        end
    endfunction

    always @(posedge clk or negedge rst_n) begin : monitor
        mean_beat_t got;
        mean_beat_t want;
        int k;
        if (!rst_n) begin
            window_reg   = '0;
            stream_count = 0;
            mismatches   = 0;
            for (k = 0; k < MAX_WINDOW; k++)
                recent[k] = '0;
            mean_queue.delete();
        end
        else begin
            if (cfg_valid && cfg_ready)
                window_reg = cfg_data;
            if (s_axis_tvalid && s_axis_tready)
                predict_means(s_axis_tdata, s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready) begin
                got.average  = m_axis_tdata;
                got.last_res = m_axis_tlast;
                if (mean_queue.size() == 0) begin
                    $error("unexpected result beat: average %0d, last_res %0b",
                           got.average, got.last_res);
                    mismatches++;
                end
                else begin
                    want = mean_queue.pop_front();
                    if (got.average !== want.average) begin
                        $error("average: expected %0d, got %0d", want.average, got.average);
                        mismatches++;
                    end
                    if (got.last_res !== want.last_res) begin
                        $error("last_res: expected %0b, got %0b", want.last_res, got.last_res);
                        mismatches++;
                    end
                end
            end
        end
        fail_count <= mismatches;
        pending    <= mean_queue.size();
    end

endmodule

/* sim/centered_moving_average_unit_tb.sv */
module centered_moving_average_unit_tb;

    import cma_pkg::*;

    localparam int HIST_DEPTH     = 31;
    localparam int ITEM_TARGET    = 215;
    localparam int STALL_LIMIT    = 3000;
    localparam int SETTLE_CYCLES  = 64;
    localparam int RX_HOLD_CYCLES = 400;
    localparam int MAX_GAP        = 8;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

    logic                clk           = 1'b0;
    logic                rst_n         = 1'b0;
    logic                cfg_valid     = 1'b0;
    logic                cfg_ready;
    logic [WLEN_W-1:0]   cfg_data      = '0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [SAMPLE_W-1:0] s_axis_tdata  = '0;
    logic                s_axis_tlast  = 1'b0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [SAMPLE_W-1:0] m_axis_tdata;
    logic                m_axis_tlast;

    logic no_gaps  = 1'b0;
    logic hold_req = 1'b0;
    int   fail_count;
    int   pending;
    int   items_sent = 0;

    initial begin
        forever #2 clk = ~clk;
    end

    centered_moving_average_unit #(
        .MAX_WINDOW (HIST_DEPTH)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    cma_result_checker #(
        .MAX_WINDOW (HIST_DEPTH)
    ) mean_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    task automatic send_sample(input logic signed [SAMPLE_W-1:0] smp, input logic fin);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= smp;
        s_axis_tlast  <= fin;
        do
            @(posedge clk);
        while (!s_axis_tready);
        items_sent++;
    endtask

    // Drop valid, wait for every expected result, then let the block go quiet.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_window(input logic [WLEN_W-1:0] value);
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return SAMPLE_MAX;
            1:       return SAMPLE_MIN;
            2:       return SAMPLE_W'($urandom_range(0, 15)) - 16'sd8;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    function automatic int pick_stream_len();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7)
            return $urandom_range(1, 12);
        else if (r < 9)
            return $urandom_range(13, 31);
        return $urandom_range(32, 45);
    endfunction

    function automatic logic [WLEN_W-1:0] pick_window();
        case ($urandom_range(0, 7))
            0:       return 5'd0;
            1:       return 5'd1;
            2:       return 5'd31;
            3:       return 5'd3;
            default: return WLEN_W'($urandom_range(2, 31));
        endcase
    endfunction

    task automatic random_stream(input int len);
        int i;
        for (i = 0; i < len; i++)
            send_sample(pick_sample(), i == len - 1);
    endtask

    initial begin : result_sink
        int gap;
        bit held;
        held = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever begin
            if (hold_req && !held) begin
                held = 1'b1;
                gap  = RX_HOLD_CYCLES;
            end
            else begin
                gap = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
            end
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!(m_axis_tvalid && m_axis_tready));
        end
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge clk);
            if (!rst_n || (s_axis_tvalid && s_axis_tready) ||
                (m_axis_tvalid && m_axis_tready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    initial begin : stimulus
        int streams;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // pass-through at the sample extremes
        write_window(5'd0);
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(SAMPLE_MIN, 1'b0);
        send_sample(-16'sd1, 1'b1);

        // even setting raised to three; then a stream of a single sample
        write_window(5'd2);
        send_sample(SAMPLE_MIN, 1'b0);
        send_sample(SAMPLE_MIN, 1'b0);
        send_sample(SAMPLE_MIN, 1'b0);
        send_sample(SAMPLE_MAX, 1'b1);
        send_sample(16'sd5, 1'b1);

        // widest window, stream shorter than half of it
        write_window(5'd31);
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(SAMPLE_MIN, 1'b1);

        write_window(5'd30);
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(-16'sd7, 1'b1);

        write_window(5'd1);
        send_sample(16'sh5555, 1'b0);
        send_sample(16'shAAAA, 1'b1);

        // long stream past saturation with the receiver held off
        write_window(5'd31);
        hold_req <= 1'b1;
        random_stream(45);

        while (items_sent < ITEM_TARGET) begin
            write_window(pick_window());
            no_gaps = ($urandom_range(0, 3) == 0);
            streams = $urandom_range(1, 4);
            repeat (streams) random_stream(pick_stream_len());
        end

        no_gaps = 1'b0;
        settle();
        if (fail_count == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

/* filelist.f */
rtl/cma_pkg.sv
rtl/cma_ram.sv
rtl/cma_queue.sv
rtl/cma_front.sv
rtl/cma_back.sv
rtl/centered_moving_average_unit.sv
rtl/cma_checker.sv
sim/cma_result_checker.sv
sim/centered_moving_average_unit_tb.sv
